[rtl/wcst_pkg.sv]
// shared types and constants of the writer change status tracker
package wcst_pkg;

  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned MASK_W     = 64;
  localparam int unsigned WINDOW_DEF = 64;
  localparam logic [SEQ_W-1:0] BASE_RESET = 32'd1;

  typedef enum logic [1:0] {
    CMD_RECEIVED    = 2'd0,
    CMD_IRRELEVANT  = 2'd1,
    CMD_LOST_UPD    = 2'd2,
    CMD_MISSING_UPD = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_UNKNOWN  = 2'd0,
    ST_MISSING  = 2'd1,
    ST_RECEIVED = 2'd2,
    ST_LOST     = 2'd3
  } status_e;

  // broadcast from the control to every cell
  typedef struct packed {
    logic             fire;
    cmd_e             cmd;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] off;
  } cell_ctl_t;

endpackage

[rtl/wcst_cell.sv]
// one window entry: status, relevance and its link in the availability chain
module wcst_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wcst_pkg::cell_ctl_t ctl_i,
  input  logic                above_i,
  output logic                above_o,
  output logic                top_o,
  output logic                missing_o,
  output logic                relevant_o
);
  import wcst_pkg::*;

  status_e          status_q, status_d;
  logic             relevant_q, relevant_d;
  logic [SEQ_W-1:0] entry_seq;
  logic             hit;
  logic             below;
  logic             avail;

  assign entry_seq = ctl_i.base + SEQ_W'(Index);
  assign hit       = (ctl_i.off == SEQ_W'(Index));
  assign below     = (entry_seq < ctl_i.seq);

  always_comb begin
    status_d   = status_q;
    relevant_d = relevant_q;
    if (ctl_i.fire) begin
      case (ctl_i.cmd)
        CMD_RECEIVED: begin
          if (hit) status_d = ST_RECEIVED;
        end
        CMD_IRRELEVANT: begin
          if (hit) begin
            status_d   = ST_RECEIVED;
            relevant_d = 1'b0;
          end
        end
        CMD_LOST_UPD: begin
          if ((status_q inside {ST_UNKNOWN, ST_MISSING}) && below) status_d = ST_LOST;
        end
        CMD_MISSING_UPD: begin
          if (status_q == ST_UNKNOWN && (below || entry_seq == ctl_i.seq)) begin
            status_d = ST_MISSING;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q   <= ST_UNKNOWN;
      relevant_q <= 1'b1;
    end else begin
      status_q   <= status_d;
      relevant_q <= relevant_d;
    end
  end

  assign avail      = (status_q inside {ST_RECEIVED, ST_LOST});
  assign above_o    = above_i | avail;
  assign top_o      = avail & ~above_i;
  assign missing_o  = (status_q == ST_MISSING);
  assign relevant_o = relevant_q;

  // an available entry stays received or lost
  a_avail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avail |=> (status_q == ST_RECEIVED || status_q == ST_LOST))
    else $error("available entry fell back");

  // an irrelevant entry was always marked received
  a_irrel_received: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !relevant_q |-> status_q == ST_RECEIVED)
    else $error("irrelevant entry not received");

endmodule

[rtl/wcst_report.sv]
// result register: encodes the highest available entry and holds the masks
module wcst_report #(
  parameter int unsigned Window = wcst_pkg::WINDOW_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic                         not_found_i,
  input  logic                         any_i,
  input  logic [wcst_pkg::SEQ_W-1:0]   base_i,
  input  logic [Window-1:0]            top_i,
  input  logic [Window-1:0]            miss_i,
  input  logic [Window-1:0]            rel_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic                         not_found_o,
  output logic                         available_valid_o,
  output logic [wcst_pkg::SEQ_W-1:0]   available_max_o,
  output logic [wcst_pkg::MASK_W-1:0]  missing_mask_o,
  output logic                         has_missing_o,
  output logic [wcst_pkg::MASK_W-1:0]  relevant_mask_o
);
  import wcst_pkg::*;

  localparam int unsigned IdxW = $clog2(Window);

  logic [IdxW-1:0]   top_idx;
  logic [SEQ_W-1:0]  max_d;
  logic [MASK_W-1:0] miss_d, rel_d;
  logic              valid_q;
  logic              not_found_q, any_q, has_missing_q;
  logic [SEQ_W-1:0]  max_q;
  logic [MASK_W-1:0] miss_q, rel_q;

  // one-hot to index
  always_comb begin
    top_idx = '0;
    for (int unsigned i = 0; i < Window; i++) begin
      top_idx = top_idx | (top_i[i] ? IdxW'(i) : '0);
    end
  end

  always_comb begin
    max_d  = any_i ? base_i + SEQ_W'(top_idx) : '0;
    miss_d = '0;
    rel_d  = '0;
    miss_d[Window-1:0] = miss_i;
    rel_d[Window-1:0]  = rel_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      not_found_q   <= not_found_i;
      any_q         <= any_i;
      max_q         <= max_d;
      miss_q        <= miss_d;
      has_missing_q <= |miss_i;
      rel_q         <= rel_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign not_found_o       = not_found_q;
  assign available_valid_o = any_q;
  assign available_max_o   = max_q;
  assign missing_mask_o    = miss_q;
  assign has_missing_o     = has_missing_q;
  assign relevant_mask_o   = rel_q;

endmodule

[rtl/writer_change_status_tracker_top.sv]
// top level of the writer change status tracker
// Tracks a reliable reader's view of one remote writer over a window of Window
// sequence numbers starting at window_base (reset value 1). Each transaction
// carries a command and a sequence number: received or irrelevant mark one
// entry, the lost and missing updates sweep every entry against the bound.
// The row of entry cells applies the command at the accepting clock edge,
// and the report register samples the updated row at the next edge; no
// new transaction is taken while the row still waits for that sample.
// The input accepts again only when the report register is free or is
// being emptied in that same cycle, so a result that waits on the output
// holds off the next transaction. Writing window_base renames the
// entries without touching their status; write it only while no transaction
// is in flight. Both masks carry zeros above bit Window-1.
module writer_change_status_tracker_top #(
  parameter int unsigned Window = wcst_pkg::WINDOW_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write
  input  logic                         cfg_we_i,
  input  logic [wcst_pkg::SEQ_W-1:0]   cfg_wdata_i,
  // command transaction
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   command_i,
  input  logic [wcst_pkg::SEQ_W-1:0]   seq_num_i,
  // result transaction
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         not_found_o,
  output logic                         available_valid_o,
  output logic [wcst_pkg::SEQ_W-1:0]   available_max_o,
  output logic [wcst_pkg::MASK_W-1:0]  missing_mask_o,
  output logic                         has_missing_o,
  output logic [wcst_pkg::MASK_W-1:0]  relevant_mask_o
);
  import wcst_pkg::*;

  logic [SEQ_W-1:0]  base_q;
  logic              calc_q;
  logic              not_found_q, not_found_d;
  logic              fire;
  logic [SEQ_W-1:0]  off;
  cmd_e              cmd;
  cell_ctl_t         ctl;

  // availability chain runs from the top entry down to entry zero
  logic [Window:0]   above;
  logic [Window-1:0] top_vec;
  logic [Window-1:0] miss_vec;
  logic [Window-1:0] rel_vec;

  // one transaction in the cell row at a time; the report register must be
  // free by the edge at which the cells finish
  assign in_ready_o = !calc_q && (!out_valid_o || out_ready_i);
  assign fire       = in_valid_i && in_ready_o;

  assign cmd = cmd_e'(command_i);
  assign off = seq_num_i - base_q;

  // only received or irrelevant can miss the window
  assign not_found_d = (cmd == CMD_RECEIVED || cmd == CMD_IRRELEVANT)
                       && (off >= SEQ_W'(Window));

  always_comb begin
    ctl.fire = fire;
    ctl.cmd  = cmd;
    ctl.seq  = seq_num_i;
    ctl.base = base_q;
    ctl.off  = off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      calc_q <= 1'b0;
    end else begin
      if (cfg_we_i) base_q <= cfg_wdata_i;
      calc_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) not_found_q <= not_found_d;
  end

  // row of entry cells
  assign above[Window] = 1'b0;

  for (genvar g = 0; g < Window; g++) begin : g_cell
    wcst_cell #(
      .Index (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .above_i    (above[g+1]),
      .above_o    (above[g]),
      .top_o      (top_vec[g]),
      .missing_o  (miss_vec[g]),
      .relevant_o (rel_vec[g])
    );
  end

  // report register, loaded the cycle after the cells update
  wcst_report #(
    .Window (Window)
  ) u_report (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (calc_q),
    .not_found_i       (not_found_q),
    .any_i             (above[0]),
    .base_i            (base_q),
    .top_i             (top_vec),
    .miss_i            (miss_vec),
    .rel_i             (rel_vec),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .not_found_o       (not_found_o),
    .available_valid_o (available_valid_o),
    .available_max_o   (available_max_o),
    .missing_mask_o    (missing_mask_o),
    .has_missing_o     (has_missing_o),
    .relevant_mask_o   (relevant_mask_o)
  );

  // every accepted transaction shows up as a result in the cycle after the update
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> ##1 out_valid_o)
    else $error("result did not follow transaction");

  // at most one set bit marks the highest available entry
  a_top_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(top_vec) && ((top_vec != '0) == above[0]))
    else $error("highest available entry not unique");

  // with nothing available the reported maximum is zero
  a_max_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !available_valid_o |-> available_max_o == '0)
    else $error("maximum reported without available entry");

  // the update commands never report a missed target
  a_update_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (cmd == CMD_LOST_UPD || cmd == CMD_MISSING_UPD) |=> !not_found_q)
    else $error("update command flagged not found");

endmodule

[sim/tb_writer_change_status_tracker_top.sv]
// testbench of the writer change status tracker: directed table, then random traffic checked by a predictor
module tb_writer_change_status_tracker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wcst_pkg::*;

  localparam int unsigned WIN              = WINDOW_DEF;
  localparam int unsigned CLK_PERIOD       = 10;
  localparam int unsigned RANDOM_PER_PHASE = 470;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned PRINT_LIMIT      = 40;
  localparam int unsigned HOLD_CYCLES      = 80;
  localparam logic [MASK_W-1:0] ALL_RELEVANT = '1;

  // one result transaction, field by field
  typedef struct packed {
    logic              not_found;
    logic              available_valid;
    logic [SEQ_W-1:0]  available_max;
    logic [MASK_W-1:0] missing_mask;
    logic              has_missing;
    logic [MASK_W-1:0] relevant_mask;
  } tracker_report_t;

  // one row of the directed table
  typedef struct packed {
    logic             base_write;  // rewrite window_base with seq, no transaction
    logic             typed;       // want holds the result, else the predictor decides
    cmd_e             cmd;
    logic [SEQ_W-1:0] seq;
    tracker_report_t  want;
  } stim_row_t;

  // every input known from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [SEQ_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [1:0]        command_i   = '0;
  logic [SEQ_W-1:0]  seq_num_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              not_found_o;
  logic              available_valid_o;
  logic [SEQ_W-1:0]  available_max_o;
  logic [MASK_W-1:0] missing_mask_o;
  logic              has_missing_o;
  logic [MASK_W-1:0] relevant_mask_o;

  // predictor copy of the tracked window
  status_e          peer_status   [WIN];
  logic             peer_relevant [WIN];
  logic [SEQ_W-1:0] tracked_base;

  // results still owed by the block, oldest first
  tracker_report_t expected_reports [$];

  int unsigned mismatch_count = 0;
  int unsigned reports_seen   = 0;
  int unsigned events_sent    = 0;
  int unsigned cycle_count    = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  writer_change_status_tracker_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .seq_num_i        (seq_num_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .not_found_o      (not_found_o),
    .available_valid_o(available_valid_o),
    .available_max_o  (available_max_o),
    .missing_mask_o   (missing_mask_o),
    .has_missing_o    (has_missing_o),
    .relevant_mask_o  (relevant_mask_o)
  );

  // applies one change event to the predicted window and reports the state after it
  function automatic tracker_report_t apply_change_event(cmd_e cmd, logic [SEQ_W-1:0] seq);
    tracker_report_t  rep;
    logic [SEQ_W-1:0] off;
    logic [SEQ_W-1:0] entry_seq;
    rep = '0;
    // offset taken mod 2^32, so targets below the base wrap far out of the window
    off = seq - tracked_base;
    case (cmd)
      CMD_RECEIVED, CMD_IRRELEVANT: begin
        if (off < WIN) begin
          peer_status[off] = ST_RECEIVED;
          if (cmd == CMD_IRRELEVANT) peer_relevant[off] = 1'b0;
        end else begin
          rep.not_found = 1'b1;
        end
      end
      CMD_LOST_UPD: begin
        // unknown or missing strictly below the first-available bound are gone
        for (int i = 0; i < WIN; i++) begin
          entry_seq = tracked_base + SEQ_W'(i);
          if ((peer_status[i] == ST_UNKNOWN || peer_status[i] == ST_MISSING) && entry_seq < seq)
            peer_status[i] = ST_LOST;
        end
      end
      default: begin
        // unknown at or below the last-available bound become missing
        for (int i = 0; i < WIN; i++) begin
          entry_seq = tracked_base + SEQ_W'(i);
          if (peer_status[i] == ST_UNKNOWN && entry_seq <= seq) peer_status[i] = ST_MISSING;
        end
      end
    endcase
    for (int i = 0; i < WIN; i++) begin
      if (peer_status[i] == ST_RECEIVED || peer_status[i] == ST_LOST) begin
        rep.available_valid = 1'b1;
        rep.available_max   = tracked_base + SEQ_W'(i);
      end
      if (peer_status[i] == ST_MISSING) rep.missing_mask[i] = 1'b1;
      if (peer_relevant[i]) rep.relevant_mask[i] = 1'b1;
    end
    rep.has_missing = |rep.missing_mask;
    return rep;
  endfunction

  // table row builders
  function automatic stim_row_t row_event(cmd_e cmd, logic [SEQ_W-1:0] seq);
    return '{base_write: 1'b0, typed: 1'b0, cmd: cmd, seq: seq, want: '0};
  endfunction

  function automatic stim_row_t row_known(cmd_e cmd, logic [SEQ_W-1:0] seq,
                                          tracker_report_t want);
    return '{base_write: 1'b0, typed: 1'b1, cmd: cmd, seq: seq, want: want};
  endfunction

  function automatic stim_row_t row_base(logic [SEQ_W-1:0] base);
    return '{base_write: 1'b1, typed: 1'b0, cmd: CMD_RECEIVED, seq: base, want: '0};
  endfunction

  // one line per mismatch, printing capped so a broken block cannot flood the log
  task automatic report_mismatch(string what, logic [MASK_W-1:0] got, logic [MASK_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] result %0d %s: got %h, want %h", $realtime, reports_seen, what, got, want);
  endtask

  // compares the result transaction taken at this edge with the oldest expectation
  task automatic check_report();
    tracker_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("result with nothing pending", '0, '0);
    end else begin
      want = expected_reports.pop_front();
      if (not_found_o !== want.not_found)
        report_mismatch("not_found", not_found_o, want.not_found);
      if (available_valid_o !== want.available_valid)
        report_mismatch("available_valid", available_valid_o, want.available_valid);
      if (available_max_o !== want.available_max)
        report_mismatch("available_max", available_max_o, want.available_max);
      if (missing_mask_o !== want.missing_mask)
        report_mismatch("missing_mask", missing_mask_o, want.missing_mask);
      if (has_missing_o !== want.has_missing)
        report_mismatch("has_missing", has_missing_o, want.has_missing);
      if (relevant_mask_o !== want.relevant_mask)
        report_mismatch("relevant_mask", relevant_mask_o, want.relevant_mask);
    end
    reports_seen++;
  endtask

  // offers one command transaction and books its result once accepted
  task automatic offer_event(cmd_e cmd, logic [SEQ_W-1:0] seq, logic typed,
                             tracker_report_t want);
    tracker_report_t predicted;
    int unsigned     gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    seq_num_i  <= seq;
    // ready is read before the edge updates it, so this is the accepting edge
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = apply_change_event(cmd, seq);
    expected_reports.push_back(typed ? want : predicted);
    events_sent++;
    // back-to-back stretches, otherwise a random gap; valid stays up when there is none
    gap = (events_sent % 200 < 40) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // drops valid and waits until every booked result has come back, plus the pipeline tail
  task automatic drain_reports();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // window_base is only rewritten with nothing in flight
  task automatic write_window_base(logic [SEQ_W-1:0] base);
    drain_reports();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= base;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    tracked_base = base;
  endtask

  // random event: targets around the window most often, else bounds near it or pure noise
  task automatic draw_event(output cmd_e cmd, output logic [SEQ_W-1:0] seq);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      cmd = CMD_RECEIVED;
      seq = tracked_base + $urandom_range(0, WIN + 1) - 1;
    end else if (pick < 45) begin
      cmd = CMD_IRRELEVANT;
      seq = tracked_base + $urandom_range(0, WIN + 1) - 1;
    end else if (pick < 60) begin
      // bounds skewed low so the window fills gradually
      cmd = CMD_MISSING_UPD;
      seq = tracked_base + $urandom_range(0, $urandom_range(0, WIN + 6)) - 3;
    end else if (pick < 72) begin
      cmd = CMD_LOST_UPD;
      seq = tracked_base + $urandom_range(0, $urandom_range(0, WIN + 6)) - 3;
    end else begin
      cmd = cmd_e'($urandom_range(0, 3));
      seq = $urandom();
    end
  endtask

  // cycle limit: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stalls, free-running stretches and two long hold-offs
  initial begin
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      // long hold-off lets the block fill up and push back on the sender
      if (reports_seen == 250 || reports_seen == 1300) hold = HOLD_CYCLES;
      else if (reports_seen % 170 < 35) hold = 0;
      else hold = $urandom_range(0, 11);
      if (hold > 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      check_report();
    end
  end

  // stimulus: reset, directed table, then random phases at several bases
  initial begin
    stim_row_t        rows [$];
    cmd_e             cmd;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] phase_bases [4];

    // predictor starts from the reset window
    tracked_base = BASE_RESET;
    for (int i = 0; i < WIN; i++) begin
      peer_status[i]   = ST_UNKNOWN;
      peer_relevant[i] = 1'b1;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // base 1 after reset: targets just outside both ends and at the top of the range
    rows.push_back(row_known(CMD_RECEIVED, 32'd0,
                             '{1'b1, 1'b0, 32'd0, 64'd0, 1'b0, ALL_RELEVANT}));
    rows.push_back(row_known(CMD_RECEIVED, 32'd65,
                             '{1'b1, 1'b0, 32'd0, 64'd0, 1'b0, ALL_RELEVANT}));
    rows.push_back(row_known(CMD_IRRELEVANT, 32'hFFFF_FFFF,
                             '{1'b1, 1'b0, 32'd0, 64'd0, 1'b0, ALL_RELEVANT}));
    // first and last entry of the window
    rows.push_back(row_known(CMD_RECEIVED, 32'd1,
                             '{1'b0, 1'b1, 32'd1, 64'd0, 1'b0, ALL_RELEVANT}));
    rows.push_back(row_known(CMD_IRRELEVANT, 32'd64,
                             '{1'b0, 1'b1, 32'd64, 64'd0, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF}));
    // missing update then lost update over part of the window, bounds of zero do nothing
    rows.push_back(row_event(CMD_MISSING_UPD, 32'd10));
    rows.push_back(row_event(CMD_MISSING_UPD, 32'd0));
    rows.push_back(row_event(CMD_LOST_UPD, 32'd5));
    rows.push_back(row_event(CMD_IRRELEVANT, 32'd6));
    rows.push_back(row_event(CMD_LOST_UPD, 32'd1));
    rows.push_back(row_event(CMD_RECEIVED, 32'd3));
    // base near the top: the window wraps through zero
    rows.push_back(row_base(32'hFFFF_FFF0));
    rows.push_back(row_event(CMD_RECEIVED, 32'hFFFF_FFFF));
    rows.push_back(row_event(CMD_RECEIVED, 32'h0000_002F));
    rows.push_back(row_event(CMD_IRRELEVANT, 32'h0000_0030));
    rows.push_back(row_event(CMD_MISSING_UPD, 32'd3));
    rows.push_back(row_event(CMD_LOST_UPD, 32'hFFFF_FFF8));
    // lowest base
    rows.push_back(row_base(32'h0));
    rows.push_back(row_event(CMD_RECEIVED, 32'd0));
    rows.push_back(row_event(CMD_RECEIVED, 32'd64));
    rows.push_back(row_event(CMD_IRRELEVANT, 32'd63));
    // highest base: entry zero is the last sequence before the wrap
    rows.push_back(row_base(32'hFFFF_FFFF));
    rows.push_back(row_event(CMD_MISSING_UPD, 32'hFFFF_FFFF));
    rows.push_back(row_event(CMD_LOST_UPD, 32'd0));
    rows.push_back(row_event(CMD_LOST_UPD, 32'h0000_0020));

    foreach (rows[k]) begin
      if (rows[k].base_write) write_window_base(rows[k].seq);
      else offer_event(rows[k].cmd, rows[k].seq, rows[k].typed, rows[k].want);
    end

    // random phases, each at its own base; a mid-phase pause lets the block run dry
    phase_bases = '{$urandom(), 32'hFFFF_FFE0, 32'h0, 32'hFFFF_FFFF};
    for (int p = 0; p < 4; p++) begin
      write_window_base(phase_bases[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n == 100) drain_reports();
        draw_event(cmd, seq);
        offer_event(cmd, seq, 1'b0, '0);
      end
    end

    drain_reports();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
rtl/wcst_pkg.sv
rtl/wcst_cell.sv
rtl/wcst_report.sv
rtl/writer_change_status_tracker_top.sv
sim/tb_writer_change_status_tracker_top.sv
